@@ sv/oidl_pkg.sv @@
// Shared types, constants and a helper function for the ordered ID list engine.
package oidl_pkg;

	localparam int MAX_ENTRIES = 8;
	localparam int ID_W = 16;
	localparam int LEN_W = 4;
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 2);

	localparam logic [ID_W-1:0] EMPTY_ID = '1;
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);

	typedef enum logic [1:0] {
		OP_TEST  = 2'd0,
		OP_ADD   = 2'd1,
		OP_DEL   = 2'd2,
		OP_FLUSH = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_INVALID  = 2'd1,
		STS_NOTFOUND = 2'd2,
		STS_RANGE    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FULL,
		S_SCAN,
		S_INS,
		S_DEL,
		S_DONE
	} state_t;

	typedef struct packed {
		opcode_t         opcode;
		logic            before_flag;
		logic            member_found;
		logic [ID_W-1:0] member_id;
		logic            member_is_list;
		logic            ref_given;
		logic            ref_found;
		logic [ID_W-1:0] ref_id;
	} in_t;

	typedef struct packed {
		status_t status;
		logic    hit;
	} out_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [ID_W-1:0]  wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic prev_empty;
		logic cur_empty;
		logic prev_id;
		logic prev_ref;
		logic pair_id_ref;
		logic pair_ref_id;
	} cmp_t;

	function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (int'(v) > MAX_ENTRIES) begin
			r = CNT_W'(MAX_ENTRIES);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

endpackage

@@ sv/oidl_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module oidl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/oidl_cmp.sv @@
// Shared compare unit that matches a slot pair against the member and reference IDs.
module oidl_cmp (
	input  logic [oidl_pkg::ID_W-1:0] prev,
	input  logic [oidl_pkg::ID_W-1:0] cur,
	input  logic                      cur_in,
	input  logic [oidl_pkg::ID_W-1:0] mid,
	input  logic [oidl_pkg::ID_W-1:0] rid,
	output oidl_pkg::cmp_t            flags
);
	import oidl_pkg::*;

	always_comb begin
		flags.prev_empty  = (prev == EMPTY_ID);
		flags.cur_empty   = (cur == EMPTY_ID);
		flags.prev_id     = (prev == mid);
		flags.prev_ref    = (prev == rid);
		flags.pair_id_ref = (prev == mid) && cur_in && (cur == rid);
		flags.pair_ref_id = (prev == rid) && cur_in && (cur == mid);
	end

endmodule

@@ sv/oidl_ctrl.sv @@
// Request sequencer that scans, inserts into and compacts the member list one slot at a time.
module oidl_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [oidl_pkg::CNT_W-1:0] len,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  oidl_pkg::in_t              in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output oidl_pkg::out_t             out_data,
	output oidl_pkg::mem_req_t         mem,
	input  logic [oidl_pkg::ID_W-1:0]  rdata
);
	import oidl_pkg::*;

	state_t               state_q, state_d, acc_next;
	opcode_t              op_q;
	logic                 before_q, refnone_q;
	logic [ID_W-1:0]      id_q, rid_q, prev_q, carry_q, cur;
	logic [CNT_W-1:0]     len_q, k_q, s1_idx_q, idx_m1, ins_k, del_k;
	logic                 s1_vld_q, s1_ent_q;
	logic [MAX_ENTRIES-1:0] vld_q;
	out_t                 res_q, out_q;
	logic                 out_valid_q;
	logic                 cur_in, accept, adv, step, last, near;
	logic                 fin, fin_hit, go_ins, go_del, flush_wr;
	status_t              fin_st, acc_st;
	cmp_t                 flags;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign cur_in = (s1_idx_q < len_q);
	assign cur    = (s1_ent_q && cur_in) ? rdata : EMPTY_ID;
	assign idx_m1 = s1_idx_q - CNT_W'(1);
	assign near   = before_q || refnone_q;
	assign step   = (state_q == S_SCAN) && s1_vld_q && (s1_idx_q != '0);
	assign last   = (s1_idx_q == len_q);
	assign ins_k  = near ? idx_m1 : s1_idx_q;
	assign del_k  = near ? s1_idx_q : s1_idx_q + CNT_W'(1);

	oidl_cmp u_cmp (
		.prev   (prev_q),
		.cur    (cur),
		.cur_in (cur_in),
		.mid    (id_q),
		.rid    (rid_q),
		.flags  (flags)
	);

	always_comb begin
		acc_st   = STS_OK;
		acc_next = S_SCAN;
		if (in_data.opcode == OP_FLUSH) begin
			acc_next = S_SCAN;
		end else if (in_data.before_flag && !in_data.ref_given) begin
			acc_next = S_DONE;
			acc_st   = STS_INVALID;
		end else if (!in_data.member_found || in_data.member_id == EMPTY_ID) begin
			acc_next = S_DONE;
			acc_st   = STS_NOTFOUND;
		end else if (in_data.opcode == OP_ADD && in_data.member_is_list) begin
			acc_next = S_DONE;
			acc_st   = STS_RANGE;
		end else if (in_data.ref_given &&
				(!in_data.ref_found || in_data.ref_id == EMPTY_ID)) begin
			acc_next = S_DONE;
			acc_st   = STS_NOTFOUND;
		end else if (in_data.opcode == OP_ADD) begin
			acc_next = S_FULL;
		end
	end

	always_comb begin
		fin      = 1'b0;
		fin_st   = STS_OK;
		fin_hit  = 1'b0;
		go_ins   = 1'b0;
		go_del   = 1'b0;
		flush_wr = 1'b0;
		case (state_q)
			S_FULL: begin
				if (s1_vld_q && !flags.cur_empty) begin
					fin    = 1'b1;
					fin_st = STS_RANGE;
				end
			end
			S_SCAN: begin
				if (step) begin
					case (op_q)
						OP_TEST: begin
							if (flags.prev_empty) begin
								fin = 1'b1;
							end else if (before_q ? flags.prev_id :
									(refnone_q ? flags.prev_id : flags.pair_ref_id)) begin
								fin     = 1'b1;
								fin_hit = before_q ? flags.pair_id_ref : 1'b1;
							end else if (last) begin
								fin = 1'b1;
							end
						end
						OP_DEL: begin
							if (flags.prev_empty) begin
								fin    = 1'b1;
								fin_st = STS_NOTFOUND;
							end else if (before_q ? flags.pair_id_ref :
									(refnone_q ? flags.prev_id : flags.pair_ref_id)) begin
								go_del = 1'b1;
							end else if (last) begin
								fin    = 1'b1;
								fin_st = STS_NOTFOUND;
							end
						end
						OP_ADD: begin
							if (flags.prev_ref) begin
								if (!near && last) begin
									fin    = 1'b1;
									fin_st = STS_RANGE;
								end else begin
									go_ins = 1'b1;
								end
							end else if (last) begin
								fin    = 1'b1;
								fin_st = STS_RANGE;
							end
						end
						default: begin
							if (flags.prev_empty) begin
								fin = 1'b1;
							end else begin
								flush_wr = 1'b1;
								fin      = last;
							end
						end
					endcase
				end
			end
			S_INS: begin
				if (s1_vld_q && (flags.cur_empty || s1_idx_q == len_q - CNT_W'(1))) begin
					fin = 1'b1;
				end
			end
			S_DEL: begin
				if (!s1_vld_q && k_q >= len_q) begin
					fin = 1'b1;
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = acc_next;
				end
			end
			S_FULL: begin
				if (fin) begin
					state_d = S_DONE;
				end else if (s1_vld_q) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (fin) begin
					state_d = S_DONE;
				end else if (go_ins) begin
					state_d = S_INS;
				end else if (go_del) begin
					state_d = S_DEL;
				end
			end
			S_INS, S_DEL: begin
				if (fin) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		adv = 1'b0;
		mem = '0;
		case (state_q)
			S_SCAN: begin
				adv = (k_q <= len_q);
				if (flush_wr) begin
					mem.we    = 1'b1;
					mem.waddr = idx_m1[IDX_W-1:0];
					mem.wdata = EMPTY_ID;
				end
			end
			S_FULL: begin
				adv = (k_q < len_q);
			end
			S_INS: begin
				adv = (k_q < len_q);
				if (s1_vld_q) begin
					mem.we    = 1'b1;
					mem.waddr = s1_idx_q[IDX_W-1:0];
					mem.wdata = carry_q;
				end
			end
			S_DEL: begin
				adv = (k_q < len_q);
				if (s1_vld_q) begin
					mem.we    = 1'b1;
					mem.waddr = idx_m1[IDX_W-1:0];
					mem.wdata = cur;
				end else if (fin) begin
					mem.we    = 1'b1;
					mem.waddr = IDX_W'(len_q - CNT_W'(1));
					mem.wdata = EMPTY_ID;
				end
			end
			default: begin
				adv = 1'b0;
			end
		endcase
		mem.re    = adv && (k_q < len_q);
		mem.raddr = k_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			s1_vld_q    <= 1'b0;
			k_q         <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			s1_vld_q <= adv && (state_d == state_q);
			if (accept) begin
				k_q <= (acc_next == S_FULL) ? len - CNT_W'(1) : '0;
			end else if (go_ins) begin
				k_q <= ins_k;
			end else if (go_del) begin
				k_q <= del_k;
			end else if (state_q == S_FULL && state_d == S_SCAN) begin
				k_q <= '0;
			end else if (adv) begin
				k_q <= k_q + CNT_W'(1);
			end
			if (mem.we) begin
				vld_q[mem.waddr] <= 1'b1;
			end
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		s1_idx_q <= k_q;
		s1_ent_q <= mem.re ? vld_q[mem.raddr] : 1'b0;
		if (accept) begin
			op_q      <= in_data.opcode;
			before_q  <= in_data.before_flag;
			refnone_q <= !in_data.ref_given;
			id_q      <= in_data.member_id;
			rid_q     <= in_data.ref_given ? in_data.ref_id : EMPTY_ID;
			len_q     <= len;
			res_q     <= '{status: acc_st, hit: 1'b0};
		end else if (fin) begin
			res_q <= '{status: fin_st, hit: fin_hit};
		end
		if (state_q == S_SCAN && s1_vld_q) begin
			prev_q <= cur;
		end
		if (go_ins) begin
			carry_q <= id_q;
		end else if (state_q == S_INS && s1_vld_q) begin
			carry_q <= cur;
		end
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_q <= res_q;
		end
	end

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		mem.re && mem.we |-> mem.raddr != mem.waddr)
		else $error("List memory read and written at the same slot.");

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !s1_vld_q)
		else $error("Read stage still busy while idle.");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld_q |-> s1_idx_q <= len_q)
		else $error("Scan index ran past the list length.");

	a_hit_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.hit && out_q.status != STS_OK))
		else $error("Hit reported with a failing status.");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_valid_q && !out_ready |=> state_q == S_DONE)
		else $error("Result dropped while the output was stalled.");

endmodule

@@ sv/ordered_id_list_engine.sv @@
// Top level of the ordered ID list engine: length register, list memory and sequencer.
// A request that fails its field checks goes straight to the done state without reading the list memory.
// One slot is read per cycle through the single read port of the list memory.
// A new request is taken only after the previous one has finished its work.
// Reset empties the list at once and sets the list length to 8.
module ordered_id_list_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [oidl_pkg::LEN_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  oidl_pkg::in_t              in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output oidl_pkg::out_t             out_data
);
	import oidl_pkg::*;

	logic [LEN_W-1:0] list_length_q;
	logic [CNT_W-1:0] len;
	mem_req_t         mem;
	logic [ID_W-1:0]  rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_length_q <= LEN_RESET;
		end else if (cfg_we) begin
			list_length_q <= cfg_wdata;
		end
	end

	assign len = eff_len(list_length_q);

	oidl_ram #(
		.WIDTH (ID_W),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (rdata)
	);

	oidl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.len       (len),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.mem       (mem),
		.rdata     (rdata)
	);

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the ordered ID list engine with a built-in list predictor.
`timescale 1ns / 100ps

module tb_top;
	import oidl_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 250;
	localparam int SETTLE_CYCLES = 30;
	localparam int RANDOM_PER_PHASE = 96;
	localparam int PHASES = 14;
	localparam int POOL_SIZE = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [LEN_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	logic [ID_W-1:0] list_ids [MAX_ENTRIES];
	logic [LEN_W-1:0] list_len = LEN_RESET;
	logic [ID_W-1:0] id_pool [POOL_SIZE];

	in_t pending_items [$];
	out_t pending_results [$];
	int issued_count = 0;
	int accepted_count = 0;
	int errors = 0;
	int cycles = 0;
	bit in_took = 1'b0;
	bit allow_idle = 1'b1;
	bit hold_phase = 1'b0;
	int hold_cnt = 0;
	int send_gap = 0;
	int recv_gap = 0;
	out_t want_result;

	ordered_id_list_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	function automatic bit slot_holds(int i, int len, logic [ID_W-1:0] v);
		return i < len && list_ids[i] == v;
	endfunction

	function automatic status_t list_insert(int pos, int len, logic [ID_W-1:0] v);
		logic [ID_W-1:0] carry;
		logic [ID_W-1:0] t;
		int j;
		if (pos >= len || list_ids[len-1] != EMPTY_ID) begin
			return STS_RANGE;
		end
		carry = v;
		for (j = pos; j < len && carry != EMPTY_ID; j++) begin
			t = list_ids[j];
			list_ids[j] = carry;
			carry = t;
		end
		return STS_OK;
	endfunction

	function automatic void list_remove(int pos, int len);
		int j;
		for (j = pos; j + 1 < len; j++) begin
			list_ids[j] = list_ids[j+1];
		end
		list_ids[len-1] = EMPTY_ID;
	endfunction

	function automatic out_t list_apply(in_t r);
		out_t res;
		int len;
		int i;
		bit done;
		logic [ID_W-1:0] refv;
		if (list_len == 0) begin
			len = 1;
		end else if (int'(list_len) > MAX_ENTRIES) begin
			len = MAX_ENTRIES;
		end else begin
			len = int'(list_len);
		end
		res.status = STS_OK;
		res.hit = 1'b0;
		refv = EMPTY_ID;
		done = 1'b0;
		if (r.opcode == OP_FLUSH) begin
			for (i = 0; i < len && list_ids[i] != EMPTY_ID; i++) begin
				list_ids[i] = EMPTY_ID;
			end
		end else if (r.before_flag && !r.ref_given) begin
			res.status = STS_INVALID;
		end else if (!r.member_found || r.member_id == EMPTY_ID) begin
			res.status = STS_NOTFOUND;
		end else if (r.opcode == OP_ADD && r.member_is_list) begin
			res.status = STS_RANGE;
		end else if (r.ref_given && (!r.ref_found || r.ref_id == EMPTY_ID)) begin
			res.status = STS_NOTFOUND;
		end else begin
			if (r.ref_given) begin
				refv = r.ref_id;
			end
			case (r.opcode)
				OP_TEST: begin
					for (i = 0; i < len && !done && list_ids[i] != EMPTY_ID; i++) begin
						if (r.before_flag) begin
							if (list_ids[i] == r.member_id) begin
								res.hit = slot_holds(i + 1, len, refv);
								done = 1'b1;
							end
						end else if ((refv == EMPTY_ID && list_ids[i] == r.member_id) ||
								(list_ids[i] == refv && slot_holds(i + 1, len, r.member_id))) begin
							res.hit = 1'b1;
							done = 1'b1;
						end
					end
				end
				OP_ADD: begin
					res.status = STS_RANGE;
					for (i = 0; i < len && !done; i++) begin
						if (list_ids[i] == refv) begin
							res.status = list_insert((r.before_flag || refv == EMPTY_ID) ? i : i + 1,
								len, r.member_id);
							done = 1'b1;
						end
					end
				end
				default: begin
					res.status = STS_NOTFOUND;
					for (i = 0; i < len && !done && list_ids[i] != EMPTY_ID; i++) begin
						if (r.before_flag) begin
							if (list_ids[i] == r.member_id && slot_holds(i + 1, len, refv)) begin
								list_remove(i, len);
								done = 1'b1;
							end
						end else if (refv == EMPTY_ID) begin
							if (list_ids[i] == r.member_id) begin
								list_remove(i, len);
								done = 1'b1;
							end
						end else if (list_ids[i] == refv && slot_holds(i + 1, len, r.member_id)) begin
							list_remove(i + 1, len);
							done = 1'b1;
						end
					end
					if (done) begin
						res.status = STS_OK;
					end
				end
			endcase
		end
		return res;
	endfunction

	function automatic in_t make_request(opcode_t op, bit bf, bit mf, logic [ID_W-1:0] mid,
			bit il, bit rg, bit rf, logic [ID_W-1:0] rid);
		in_t r;
		r.opcode = op;
		r.before_flag = bf;
		r.member_found = mf;
		r.member_id = mid;
		r.member_is_list = il;
		r.ref_given = rg;
		r.ref_found = rf;
		r.ref_id = rid;
		return r;
	endfunction

	function automatic in_t random_request();
		in_t r;
		logic [63:0] raw;
		int k;
		opcode_t op;
		bit rg;
		k = $urandom_range(0, 99);
		if (k < 10) begin
			raw = {$urandom(), $urandom()};
			r = raw[$bits(in_t)-1:0];
		end else begin
			k = $urandom_range(0, 99);
			if (k < 35) begin
				op = OP_ADD;
			end else if (k < 60) begin
				op = OP_DEL;
			end else if (k < 95) begin
				op = OP_TEST;
			end else begin
				op = OP_FLUSH;
			end
			rg = $urandom_range(0, 1);
			r = make_request(op, rg ? $urandom_range(0, 1) : 1'b0, $urandom_range(0, 19) != 0,
				id_pool[$urandom_range(0, POOL_SIZE - 1)], $urandom_range(0, 19) == 0, rg,
				$urandom_range(0, 19) != 0, id_pool[$urandom_range(0, POOL_SIZE - 1)]);
		end
		return r;
	endfunction

	task automatic queue_request(in_t r);
		pending_items.push_back(r);
		issued_count++;
	endtask

	task automatic wait_drained();
		while (accepted_count != issued_count || pending_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_length(logic [LEN_W-1:0] v);
		@(negedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		list_len = v;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_took) begin
				in_valid <= 1'b1;
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (allow_idle && $urandom_range(0, 4) == 0) begin
				send_gap = $urandom_range(1, 3) - 1;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
			in_took = 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_phase && hold_cnt < HOLD_CYCLES) begin
			hold_cnt++;
			out_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_ready <= 1'b0;
		end else if (allow_idle && $urandom_range(0, 4) == 0) begin
			recv_gap = $urandom_range(1, 3) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				pending_results.push_back(list_apply(in_data));
				accepted_count++;
				in_took = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("Unexpected result transfer: status %0d hit %0d",
							out_data.status, out_data.hit);
					end
				end else begin
					want_result = pending_results.pop_front();
					if (out_data.status !== want_result.status || out_data.hit !== want_result.hit) begin
						errors++;
						if (errors <= 10) begin
							$display("Result mismatch: status exp %0d got %0d, hit exp %0d got %0d",
								want_result.status, out_data.status, want_result.hit, out_data.hit);
						end
					end
				end
			end
		end
	end

	initial begin
		int p;
		int n;
		logic [LEN_W-1:0] lengths [PHASES];
		lengths = '{4'd15, 4'd1, 4'd0, 4'd8, 4'd3, 4'd5, 4'd2, 4'd8, 4'd7, 4'd4, 4'd6,
			4'd15, 4'd8, 4'd1};
		for (n = 0; n < MAX_ENTRIES; n++) begin
			list_ids[n] = EMPTY_ID;
		end
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		queue_request(make_request(OP_TEST, 0, 1, 16'h0000, 0, 0, 0, 16'h0000));
		queue_request(make_request(OP_ADD, 0, 1, 16'h0000, 0, 0, 0, 16'h0000));
		queue_request(make_request(OP_ADD, 0, 1, 16'hFFFE, 0, 0, 0, 16'h0000));
		queue_request(make_request(OP_ADD, 1, 1, 16'h1234, 0, 1, 1, 16'hFFFE));
		queue_request(make_request(OP_ADD, 0, 1, 16'h00FF, 0, 1, 1, 16'h0000));
		queue_request(make_request(OP_TEST, 1, 1, 16'h1234, 0, 1, 1, 16'hFFFE));
		queue_request(make_request(OP_TEST, 0, 1, 16'h00FF, 0, 1, 1, 16'h0000));
		queue_request(make_request(OP_TEST, 0, 1, 16'hFFFE, 0, 0, 0, 16'h0000));
		queue_request(make_request(OP_TEST, 1, 1, 16'h1234, 0, 0, 1, 16'hFFFE));
		queue_request(make_request(OP_ADD, 0, 0, 16'h1234, 0, 0, 0, 16'h0000));
		queue_request(make_request(OP_ADD, 0, 1, 16'hFFFF, 0, 0, 0, 16'h0000));
		queue_request(make_request(OP_ADD, 0, 1, 16'h4321, 1, 0, 0, 16'h0000));
		queue_request(make_request(OP_ADD, 0, 1, 16'h4321, 0, 1, 0, 16'h0000));
		queue_request(make_request(OP_TEST, 0, 1, 16'h1234, 0, 1, 1, 16'hFFFF));
		queue_request(make_request(OP_ADD, 0, 1, 16'h5555, 0, 1, 1, 16'h4321));
		queue_request(make_request(OP_ADD, 0, 1, 16'h0000, 0, 0, 0, 16'h0000));
		queue_request(make_request(OP_DEL, 1, 1, 16'h1234, 0, 1, 1, 16'hFFFE));
		queue_request(make_request(OP_DEL, 0, 1, 16'hFFFE, 0, 1, 1, 16'h00FF));
		queue_request(make_request(OP_DEL, 0, 1, 16'h0000, 0, 0, 1, 16'h0000));
		queue_request(make_request(OP_DEL, 0, 1, 16'h4321, 0, 0, 0, 16'h0000));
		queue_request(make_request(OP_FLUSH, 1, 0, 16'hFFFF, 1, 1, 0, 16'hFFFF));
		wait_drained();

		set_length(4'd2);
		queue_request(make_request(OP_ADD, 0, 1, 16'h1234, 0, 0, 0, 16'h0000));
		queue_request(make_request(OP_ADD, 0, 1, 16'hFFFE, 0, 0, 0, 16'h0000));
		queue_request(make_request(OP_ADD, 1, 1, 16'h0000, 0, 1, 1, 16'h1234));
		queue_request(make_request(OP_FLUSH, 0, 0, 16'h0000, 0, 0, 0, 16'h0000));
		wait_drained();

		for (p = 0; p < PHASES; p++) begin
			id_pool[0] = 16'h0000;
			id_pool[1] = 16'hFFFE;
			for (n = 2; n < POOL_SIZE; n++) begin
				id_pool[n] = $urandom_range(0, 65534);
			end
			set_length(lengths[p]);
			allow_idle = (p < PHASES - 2) && (p % 3 != 1);
			if (p == 3) begin
				hold_phase = 1'b1;
			end
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				queue_request(random_request());
			end
			wait_drained();
		end

		if (errors == 0 && pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
